// ----- hdl/floyd_steinberg_palette_dither_top_macros.svh -----
// assertion macros for the palette dither block
`ifndef FLOYD_STEINBERG_PALETTE_DITHER_TOP_MACROS_SVH
`define FLOYD_STEINBERG_PALETTE_DITHER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FSD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FSD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define FSD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- hdl/fsd_pkg.sv -----
// shared types, constants and helpers of the palette dither block
package fsd_pkg;
	localparam int CH = 4;
	localparam int ERR_W = 11;
	localparam int DIST_W = 18;
	localparam int PSZ_W = 9;

	typedef logic [CH-1:0][7:0] rgba_t;
	typedef logic [CH-1:0][ERR_W-1:0] err4_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADJ,
		S_SRCH,
		S_DRN,
		S_PE,
		S_OUTW,
		S_UPD,
		S_WR2
	} state_t;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PSIZE = 2'd2;

	// divide by sixteen, truncating toward zero
	function automatic logic signed [ERR_W-1:0] div16(input logic signed [12:0] v);
		logic signed [12:0] a;
		a = v + ((v < 13'sd0) ? 13'sd15 : 13'sd0);
		return ERR_W'(a >>> 4);
	endfunction
endpackage

// ----- hdl/fsd_dist.sv -----
// registered squared rgba distance unit shared by every palette compare
module fsd_dist (
	input  logic                        clk,
	input  fsd_pkg::rgba_t              pix,
	input  fsd_pkg::rgba_t              ent,
	output logic [fsd_pkg::DIST_W-1:0]  dist_q
);
	import fsd_pkg::*;

	logic [DIST_W-1:0] sum;

	always_comb begin
		logic signed [8:0] d;
		logic [15:0] sq;
		sum = '0;
		for (int c = 0; c < CH; c++) begin
			d = $signed({1'b0, pix[c]}) - $signed({1'b0, ent[c]});
			sq = 16'(d * d);
			sum = sum + DIST_W'(sq);
		end
	end

	always_ff @(posedge clk) begin
		dist_q <= sum;
	end
endmodule

// ----- hdl/floyd_steinberg_palette_dither_top.sv -----
// top level of the floyd-steinberg palette dither engine
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tuser cmd, tdata entry/rgba
//  m_       out  m_tvalid/m_tready    tdata palette_index, tlast frame_done
//  cfg_     in   cfg_we               cfg_index, cfg_data
// a palette load is accepted in idle; a pixel passes adjust, search, drain, error,
// output wait and update before the next ready, and a second error write at the end
// of a non-last row; the single distance unit walks the palette one entry per cycle
// the next pixel is taken while a result still waits in the output register
// an output stall holds a pixel in its output wait state until the register frees
// reset clears control state; palette and row error memories are not cleared
`include "floyd_steinberg_palette_dither_top_macros.svh"
module floyd_steinberg_palette_dither_top #(
	parameter int MAX_WIDTH = 1024,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // entry_index, red, green, blue, alpha
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // palette_index
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import fsd_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int PW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [15:0] MAXW16 = 16'(MAX_WIDTH);
	localparam logic [PSZ_W-1:0] MAXP = PSZ_W'(PALETTE_ENTRIES);

	state_t state_q, state_d;

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [PSZ_W-1:0] psize_q;

	logic [XW-1:0] col_q;
	logic [15:0] row_q;

	rgba_t pal_mem [PALETTE_ENTRIES];
	err4_t err_mem [MAX_WIDTH];
	rgba_t pal_rd_q;
	err4_t err_rd_q;

	rgba_t in_q, px_q, ent2_q, best_ent_q;
	err4_t right_q, bp0_q, bp1_q, wr2_q;
	logic [XW-1:0] wr2_col_q;
	logic [CH-1:0][9:0] pe_q;
	logic [PSZ_W-1:0] cnt_q;
	logic [PW-1:0] idx1_q, idx2_q, best_q;
	logic v1_q, v2_q;
	logic [DIST_W-1:0] dist_q, best_d_q;
	logic wr2_pend_q;

	logic [15:0] weff;
	logic [15:0] heff;
	logic [PSZ_W-1:0] neff;
	logic last_col, last_row, first_col;
	logic s_acc;
	logic pal_we, err_we;
	logic [XW-1:0] err_wa;
	err4_t err_wd;
	logic [PW-1:0] pal_ra;
	rgba_t px_d;
	err4_t below_d, t7_d, t1_d, t3_d;

	assign weff = (width_q == 11'd0) ? 16'd1 :
		((16'(width_q) > MAXW16) ? MAXW16 : 16'(width_q));
	assign heff = (height_q == 16'd0) ? 16'd1 : height_q;
	assign neff = (psize_q == '0) ? PSZ_W'(1) : ((psize_q > MAXP) ? MAXP : psize_q);
	assign last_col = (16'(col_q) + 16'd1) >= weff;
	assign last_row = (17'(row_q) + 17'd1) >= 17'(heff);
	assign first_col = (col_q == '0);
	assign s_tready = (state_q == S_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign pal_we = s_acc && !s_tuser && ({1'b0, s_tdata[7:0]} < MAXP);
	assign pal_ra = cnt_q[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1;
			height_q <= 16'd1;
			psize_q <= PSZ_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				REG_PSIZE: psize_q <= cfg_data[PSZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pal_we) pal_mem[s_tdata[PW-1:0]] <= rgba_t'(s_tdata[39:8]);
		pal_rd_q <= pal_mem[pal_ra];
	end

	always_ff @(posedge clk) begin
		if (err_we) err_mem[err_wa] <= err_wd;
		err_rd_q <= err_mem[col_q];
	end

	fsd_dist u_dist (
		.clk(clk),
		.pix(px_q),
		.ent(pal_rd_q),
		.dist_q(dist_q)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_acc && s_tuser) state_d = S_ADJ;
			S_ADJ: state_d = S_SRCH;
			S_SRCH: if (cnt_q + PSZ_W'(1) == neff) state_d = S_DRN;
			S_DRN: if (v2_q && !v1_q) state_d = S_PE;
			S_PE: state_d = S_OUTW;
			S_OUTW: if (!m_tvalid || m_tready) state_d = S_UPD;
			S_UPD: state_d = (last_col && !last_row) ? S_WR2 : S_IDLE;
			S_WR2: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		logic signed [11:0] v;
		logic signed [12:0] pex;
		logic signed [ERR_W-1:0] b0, b1;
		for (int c = 0; c < CH; c++) begin
			v = 12'(in_q[c]) + (first_col ? 12'sd0 : 12'($signed(right_q[c])))
				+ ((row_q != 16'd0) ? 12'($signed(err_rd_q[c])) : 12'sd0);
			px_d[c] = (v < 12'sd0) ? 8'd0 : ((v > 12'sd255) ? 8'd255 : v[7:0]);
			pex = 13'($signed(pe_q[c]));
			b0 = first_col ? '0 : $signed(bp0_q[c]);
			b1 = first_col ? '0 : $signed(bp1_q[c]);
			t7_d[c] = div16(pex * 13'sd7);
			t1_d[c] = div16(pex);
			below_d[c] = b1 + div16(pex * 13'sd5);
			t3_d[c] = b0 + div16(pex * 13'sd3);
		end
	end

	always_comb begin
		err_we = 1'b0;
		err_wa = col_q;
		err_wd = wr2_q;
		case (state_q)
			S_UPD: begin
				err_we = !last_row && !first_col;
				err_wa = col_q - XW'(1);
				err_wd = t3_d;
			end
			S_WR2: begin
				err_we = wr2_pend_q;
				err_wa = wr2_col_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q <= '0;
			row_q <= '0;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			m_tvalid <= 1'b0;
			wr2_pend_q <= 1'b0;
			right_q <= '0;
			bp0_q <= '0;
			bp1_q <= '0;
		end else begin
			state_q <= state_d;
			v1_q <= (state_q == S_SRCH);
			v2_q <= v1_q;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (state_q == S_UPD) begin
				m_tvalid <= 1'b1;
				wr2_pend_q <= last_col && !last_row;
				if (!last_row) begin
					bp0_q <= below_d;
					bp1_q <= last_col ? '0 : t1_d;
				end
				right_q <= last_col ? '0 : t7_d;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) in_q <= rgba_t'(s_tdata[39:8]);
		if (state_q == S_ADJ) begin
			px_q <= px_d;
			cnt_q <= '0;
			best_d_q <= '1;
		end
		if (state_q == S_SRCH) cnt_q <= cnt_q + PSZ_W'(1);
		idx1_q <= pal_ra;
		idx2_q <= idx1_q;
		ent2_q <= pal_rd_q;
		if (v2_q && (dist_q <= best_d_q)) begin
			best_d_q <= dist_q;
			best_q <= idx2_q;
			best_ent_q <= ent2_q;
		end
		if (state_q == S_PE) begin
			for (int c = 0; c < CH; c++)
				pe_q[c] <= 10'(px_q[c]) - 10'(best_ent_q[c]);
		end
		if (state_q == S_UPD) begin
			m_tdata <= 8'(best_q);
			m_tlast <= last_col && last_row;
			wr2_q <= below_d;
			wr2_col_q <= col_q;
		end
	end

	`FSD_ASSERT_IMPL(a_upd_slot_free, clk, arst_n, state_q == S_UPD, !m_tvalid)
	`FSD_ASSERT_NEXT(a_done_wraps, clk, arst_n,
		state_q == S_UPD && last_col && last_row, col_q == '0 && row_q == 16'd0)
	`FSD_ASSERT_IMPL(a_no_write_last_row, clk, arst_n,
		state_q == S_UPD && last_row, !err_we)
	`FSD_ASSERT_IMPL(a_busy_no_ready, clk, arst_n, v1_q || v2_q, !s_tready)
endmodule

// ----- bench/floyd_steinberg_palette_dither_top_test.sv -----
// self-checking testbench of the floyd-steinberg palette dither engine
module floyd_steinberg_palette_dither_top_test;
	import fsd_pkg::*;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;
	localparam int MAXW = 1024;
	localparam int NPAL = 256;
	localparam int SETTLE = 300;
	localparam longint LIMIT = 3000000;

	typedef struct packed {
		logic [7:0] index;
		logic       done;
	} dither_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // entry_index, red, green, blue, alpha
	logic        s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // palette_index
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	floyd_steinberg_palette_dither_top dut (.*);

	// shadow state of the block
	logic [7:0] pal_mem [NPAL][4];
	int         row_err [MAXW][4];
	int         err_right [4];
	int         err_below [2][4];
	int         col_pos, row_pos;
	logic [10:0] cfg_w;
	logic [15:0] cfg_h;
	logic [8:0]  cfg_p;

	dither_out_t expected_q[$];
	int send_idle_pct, recv_stall_pct;
	int mismatches, results_seen, pixels_sent, loads_sent;
	longint cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (expected_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result index %0d last %0b", m_tdata, m_tlast);
			end else begin
				dither_out_t e;
				e = expected_q.pop_front();
				if (e.index !== m_tdata || e.done !== m_tlast) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected index %0d last %0b, got %0d %0b",
							e.index, e.done, m_tdata, m_tlast);
				end
			end
		end
	end

	function automatic int eff_width();
		if (cfg_w == 0) return 1;
		if (cfg_w > MAXW) return MAXW;
		return cfg_w;
	endfunction

	function automatic int eff_palette();
		if (cfg_p == 0) return 1;
		if (cfg_p > NPAL) return NPAL;
		return cfg_p;
	endfunction

	function automatic void predict_dither(input logic [7:0] ch [4]);
		int w, h, x, n, best, d, diff;
		longint best_d;
		int px [4];
		int pe [4];
		int below;
		logic last_col, last_row, done;
		dither_out_t r;
		w = eff_width();
		h = (cfg_h == 0) ? 1 : cfg_h;
		n = eff_palette();
		x = (col_pos >= MAXW) ? MAXW - 1 : col_pos;
		last_col = (x + 1 >= w);
		last_row = (row_pos + 1 >= h);
		if (x == 0) begin
			for (int c = 0; c < 4; c++) begin
				err_right[c] = 0;
				err_below[0][c] = 0;
				err_below[1][c] = 0;
			end
		end
		for (int c = 0; c < 4; c++) begin
			px[c] = ch[c] + err_right[c] + ((row_pos > 0) ? row_err[x][c] : 0);
			if (px[c] < 0) px[c] = 0;
			if (px[c] > 255) px[c] = 255;
		end
		best = 0;
		best_d = 64'hFFFFFFFF;
		for (int i = 0; i < n; i++) begin
			d = 0;
			for (int c = 0; c < 4; c++) begin
				diff = px[c] - pal_mem[i][c];
				d += diff * diff;
			end
			if (d <= best_d) begin
				best_d = d;
				best = i;
			end
		end
		for (int c = 0; c < 4; c++) pe[c] = px[c] - pal_mem[best][c];
		for (int c = 0; c < 4; c++) begin
			if (!last_row) begin
				below = err_below[1][c] + pe[c] * 5 / 16;
				if (x >= 1) row_err[x - 1][c] = err_below[0][c] + pe[c] * 3 / 16;
				err_below[0][c] = below;
				err_below[1][c] = last_col ? 0 : pe[c] / 16;
				if (last_col) row_err[x][c] = below;
			end
			err_right[c] = last_col ? 0 : pe[c] * 7 / 16;
		end
		done = 1'b0;
		if (last_col) begin
			col_pos = 0;
			if (last_row) begin
				row_pos = 0;
				done = 1'b1;
			end else begin
				row_pos = (row_pos + 1) & 16'hFFFF;
			end
		end else begin
			col_pos = x + 1;
		end
		r.index = best[7:0];
		r.done = done;
		expected_q.push_back(r);
	endfunction

	task automatic send_request(input logic cmd, input logic [7:0] slot,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] a);
		logic [7:0] ch [4];
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {a, b, g, r, slot};
		do @(posedge clk); while (!s_tready);
		ch[0] = r; ch[1] = g; ch[2] = b; ch[3] = a;
		if (cmd == CMD_LOAD) begin
			for (int c = 0; c < 4; c++) pal_mem[slot][c] = ch[c];
			loads_sent++;
		end else begin
			predict_dither(ch);
			pixels_sent++;
		end
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		send_request(CMD_PIXEL, 8'($urandom_range(255)), r, g, b, a);
	endtask

	task automatic send_random_pixel();
		logic [7:0] v [4];
		for (int c = 0; c < 4; c++) begin
			case ($urandom_range(5))
				0: v[c] = 8'd0;
				1: v[c] = 8'd255;
				default: v[c] = 8'($urandom_range(255));
			endcase
		end
		send_pixel(v[0], v[1], v[2], v[3]);
	endtask

	task automatic send_random_load(input int slot);
		send_request(CMD_LOAD, 8'(slot), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH: cfg_w = val[10:0];
			REG_HEIGHT: cfg_h = val;
			REG_PSIZE: cfg_p = val[8:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int w, input int h, input int p);
		wait_idle();
		write_reg(REG_WIDTH, 16'(w));
		write_reg(REG_HEIGHT, 16'(h));
		write_reg(REG_PSIZE, 16'(p));
	endtask

	task automatic test_directed();
		configure(3, 2, 8);
		send_request(CMD_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_request(CMD_LOAD, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255);
		send_request(CMD_LOAD, 8'd2, 8'd128, 8'd64, 8'd32, 8'd16);
		// identical entries, tie goes to the higher slot
		send_request(CMD_LOAD, 8'd3, 8'd128, 8'd64, 8'd32, 8'd16);
		send_request(CMD_LOAD, 8'd4, 8'd255, 8'd0, 8'd0, 8'd255);
		send_request(CMD_LOAD, 8'd5, 8'd0, 8'd255, 8'd0, 8'd0);
		send_request(CMD_LOAD, 8'd6, 8'd0, 8'd0, 8'd255, 8'd128);
		send_request(CMD_LOAD, 8'd7, 8'd170, 8'd85, 8'd170, 8'd85);
		send_request(CMD_LOAD, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd128, 8'd64, 8'd32, 8'd16);
		send_pixel(8'd250, 8'd5, 8'd250, 8'd5);
		send_pixel(8'd127, 8'd127, 8'd127, 8'd127);
		send_pixel(8'd0, 8'd255, 8'd0, 8'd255);
	endtask

	task automatic test_full_palette();
		for (int i = 0; i < NPAL; i++) send_random_load(i);
		configure(4, 2, 511);
		repeat (8) send_random_pixel();
		configure(3, 1, 256);
		repeat (3) send_random_pixel();
	endtask

	task automatic test_register_extremes();
		configure(0, 0, 0);
		repeat (3) send_random_pixel();
		configure(2047, 1, 4);
		repeat (24) send_random_pixel();
		// narrowing the row makes the next column the last one
		wait_idle();
		write_reg(REG_WIDTH, 16'd25);
		send_random_pixel();
	endtask

	task automatic test_height_shrink();
		configure(1, 65535, 6);
		repeat (5) send_random_pixel();
		// position now beyond the new height, so this row ends the frame
		wait_idle();
		write_reg(REG_HEIGHT, 16'd1);
		send_random_pixel();
	endtask

	task automatic test_random_frames(input int send_pct, input int recv_pct,
			input int n_items);
		int w, h, start;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start = pixels_sent + loads_sent;
		while (pixels_sent + loads_sent - start < n_items) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
			h = $urandom_range(4, 1);
			configure(w, h, ($urandom_range(19) == 0) ? 256 : $urandom_range(10, 1));
			for (int i = 0; i < w * h; i++) begin
				if ($urandom_range(9) == 0) send_random_load($urandom_range(255));
				send_random_pixel();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		mismatches = 0;
		results_seen = 0;
		pixels_sent = 0;
		loads_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		col_pos = 0;
		row_pos = 0;
		cfg_w = 1;
		cfg_h = 1;
		cfg_p = 1;
		for (int c = 0; c < 4; c++) begin
			err_right[c] = 0;
			err_below[0][c] = 0;
			err_below[1][c] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_palette();
		test_register_extremes();
		test_height_shrink();
		test_random_frames(0, 0, 60);
		test_random_frames(52, 0, 60);
		test_random_frames(0, 52, 60);
		test_random_frames(37, 37, 60);
		wait_idle();
		$display("covered %0d pixels and %0d palette loads, %0d results checked",
			pixels_sent, loads_sent, results_seen);
		$display("frames up to 40 wide, clamped register values, palettes 1..256");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
